[hw/rtl/awrr_pkg.sv]
// ----------------------------------------------------------------------------
// awrr_pkg: shared types and constants of the ack window reorder receiver
// Sizes of the reorder window, the result run cap, the front queue, and the
// item records that move between the front and the back of the block.
// ----------------------------------------------------------------------------
package awrr_pkg;

   // Keep REORDER_DEPTH a power of two: a slot index is the low sequence bits
   localparam int REORDER_DEPTH = 32;
   localparam int SLOT_IDX_W    = $clog2(REORDER_DEPTH);
   localparam int MAX_RESULTS   = 32;
   localparam int RUN_CNT_W     = $clog2(MAX_RESULTS + 1);

   localparam int SEQ_W         = 32;
   localparam int TAG_W         = 16;
   localparam int LEN_W         = 11;
   localparam int ACK_W         = 32;
   localparam int ACK_SHIFT_W   = $clog2(ACK_W);

   localparam int QUEUE_DEPTH   = 2;
   localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_IN_ORDER  = 2'd0,
      STATUS_BUFFERED  = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_BEYOND    = 2'd3
   } status_type;

   // Arrival after the ack update, as handed from front to back
   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      logic [TAG_W-1:0] buffer_tag;
      logic [LEN_W-1:0] payload_len;
      logic [SEQ_W-1:0] ack_seq;
      logic [ACK_W-1:0] ack_bits;
   } arrival_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [LEN_W-1:0] len;
   } slot_entry_type;

   localparam int SLOT_ENTRY_W = $bits(slot_entry_type);

endpackage

[hw/rtl/awrr_channels.sv]
// ----------------------------------------------------------------------------
// awrr_channels: item channels of the ack window reorder receiver
// Valid/ready channels for arriving packets and for result items.
// ----------------------------------------------------------------------------
interface awrr_req_if
   import awrr_pkg::*;
;
   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] seq_num;
   logic [TAG_W-1:0] buffer_tag;
   logic [LEN_W-1:0] payload_len;

   modport source (output valid, output seq_num, output buffer_tag, output payload_len,
                   input ready);
   modport sink   (input valid, input seq_num, input buffer_tag, input payload_len,
                   output ready);
endinterface

interface awrr_rsp_if
   import awrr_pkg::*;
;
   logic             valid;
   logic             ready;
   logic             deliver_valid;
   logic [SEQ_W-1:0] deliver_seq;
   logic [TAG_W-1:0] deliver_tag;
   logic [LEN_W-1:0] deliver_len;
   logic [SEQ_W-1:0] ack_seq;
   logic [ACK_W-1:0] ack_bits;
   logic [1:0]       arrival_status;
   logic             last_of_run;

   modport source (output valid, output deliver_valid, output deliver_seq,
                   output deliver_tag, output deliver_len, output ack_seq,
                   output ack_bits, output arrival_status, output last_of_run,
                   input ready);
   modport sink   (input valid, input deliver_valid, input deliver_seq,
                   input deliver_tag, input deliver_len, input ack_seq,
                   input ack_bits, input arrival_status, input last_of_run,
                   output ready);
endinterface

[hw/rtl/ack_window_reorder_receiver_top.sv]
// ----------------------------------------------------------------------------
// ack_window_reorder_receiver_top: receive-side reorder and selective ack
// Track the highest sequence and ack bitmap, reorder early packets in a
// slot window and deliver them in sequence order.
// ----------------------------------------------------------------------------
// Each arriving packet (req_ch) produces one result of its own, followed by
// in-order deliveries of any consecutive packets waiting in the reorder
// window; the final result of an arrival carries last_of_run. Every result
// carries the highest sequence and ack bitmap as updated by that arrival.
// The front end updates the ack state and accepts one arrival per cycle while
// the two-entry queue has room; the reorder engine takes one arrival every
// cycle it is idle and the result register is free. Each drained delivery
// passes through a slot RAM read and then a result load, and the engine
// takes no new arrival until its run is done, at most 32 results per
// arrival; a longer run resumes after the next arrival's own result. A write
// on csr_wr_data sets the next expected sequence and empties the window; the
// engine takes arrivals again on the next cycle. Write it only with nothing in
// flight. While a result waits on rsp_ch.ready the queue keeps taking
// arrivals while it has room, and an engine in its idle or emit state loads
// its next result, if it has one, in the cycle the waiting one is accepted.
module ack_window_reorder_receiver_top
   import awrr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   awrr_req_if.sink         req_ch,
   awrr_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [SEQ_W-1:0] csr_wr_data
);

   // front end to queue
   logic        push_valid;
   logic        push_ready;
   arrival_type push_data;

   // queue to reorder engine
   logic        pop_valid;
   logic        pop_ready;
   arrival_type pop_data;

   // Update highest sequence and ack bitmap on acceptance
   awrr_ack_tracker u_ack_tracker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Hold arrivals while the engine drains
   awrr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Classify, buffer and drain in order
   awrr_reorder_engine u_reorder_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_ch      (rsp_ch)
   );

   // A result delivers a payload exactly when its status says in order
   a_status_matches_delivery : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.deliver_valid == (rsp_ch.arrival_status == STATUS_IN_ORDER)))
      else $error("delivery flag disagrees with arrival status");

   // The ack snapshot never trails the arrival it travels with
   a_ack_covers_arrival : assert property (@(posedge clock) disable iff (reset)
      (push_valid && push_ready) |-> (push_data.ack_seq >= push_data.seq_num))
      else $error("ack sequence below arriving sequence");

   // Taking an arrival from the queue always presents a result next cycle
   a_pop_makes_result : assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready && !csr_wr_en) |=> rsp_ch.valid)
      else $error("arrival consumed without a result");

endmodule

[hw/rtl/awrr_ram.sv]
// ----------------------------------------------------------------------------
// awrr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held until the
// next read.
// ----------------------------------------------------------------------------
module awrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/awrr_ack_tracker.sv]
// ----------------------------------------------------------------------------
// awrr_ack_tracker: front end, highest sequence and selective-ack bitmap
// Accept arrivals, update the ack state and push each arrival with its ack
// snapshot into the queue.
// ----------------------------------------------------------------------------
module awrr_ack_tracker
   import awrr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   awrr_req_if.sink      req_ch,
   output logic          push_valid,
   input  logic          push_ready,
   output arrival_type   push_data
);

   logic [SEQ_W-1:0] highest_ff, highest_in;
   logic [ACK_W-1:0] mask_ff, mask_in;
   logic [SEQ_W-1:0] dist_up;
   logic [SEQ_W-1:0] dist_down;

   always_comb begin
      dist_up    = req_ch.seq_num - highest_ff;
      dist_down  = highest_ff - req_ch.seq_num;
      highest_in = highest_ff;
      mask_in    = mask_ff;
      if (req_ch.seq_num > highest_ff) begin
         // shift the window forward, clear it on a long jump
         highest_in = req_ch.seq_num;
         mask_in    = ((dist_up >= SEQ_W'(ACK_W)) ? '0 : (mask_ff << dist_up[ACK_SHIFT_W-1:0]))
                      | ACK_W'(1);
      end else if (dist_down < SEQ_W'(ACK_W)) begin
         mask_in = mask_ff | (ACK_W'(1) << dist_down[ACK_SHIFT_W-1:0]);
      end
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_data.seq_num     = req_ch.seq_num;
      push_data.buffer_tag  = req_ch.buffer_tag;
      push_data.payload_len = req_ch.payload_len;
      push_data.ack_seq     = highest_in;
      push_data.ack_bits    = mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         highest_ff <= '0;
         mask_ff    <= '0;
      end else if (req_ch.valid && push_ready) begin
         highest_ff <= highest_in;
         mask_ff    <= mask_in;
      end
   end

endmodule

[hw/rtl/awrr_queue.sv]
// ----------------------------------------------------------------------------
// awrr_queue: short FIFO between the ack front end and the reorder engine
// Decouple arrival acceptance from drain runs.
// ----------------------------------------------------------------------------
module awrr_queue
   import awrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  arrival_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output arrival_type pop_data
);

   arrival_type        entries_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               push_fire, pop_fire;

   function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] ptr);
      return (ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign push_ready = (count_ff != Q_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         end
         if (pop_fire) begin
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         end
         count_ff <= count_in;
      end
   end

endmodule

[hw/rtl/awrr_reorder_engine.sv]
// ----------------------------------------------------------------------------
// awrr_reorder_engine: back end, classification, reorder window and drain
// Classify each arrival against the expected sequence, hold early packets
// in the slot RAM and drain consecutive slots into the result register.
// ----------------------------------------------------------------------------
module awrr_reorder_engine
   import awrr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [SEQ_W-1:0] csr_wr_data,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  arrival_type      pop_data,
   awrr_rsp_if.source       rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [SEQ_W-1:0]         exp_ff, exp_in;
   logic [SLOT_IDX_W-1:0]    exp_idx_ff, exp_idx_in;
   logic [REORDER_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [RUN_CNT_W-1:0]     run_cnt_ff, run_cnt_in;

   logic                     out_valid_ff, out_valid_in;
   logic                     dlv_valid_ff, dlv_valid_in;
   logic [SEQ_W-1:0]         dlv_seq_ff, dlv_seq_in;
   logic [TAG_W-1:0]         dlv_tag_ff, dlv_tag_in;
   logic [LEN_W-1:0]         dlv_len_ff, dlv_len_in;
   logic [SEQ_W-1:0]         ack_seq_ff, ack_seq_in;
   logic [ACK_W-1:0]         ack_bits_ff, ack_bits_in;
   status_type               status_ff, status_in;
   logic                     last_ff, last_in;

   logic                     out_free;
   logic [SLOT_IDX_W-1:0]    exp_idx_inc;
   logic [SLOT_IDX_W-1:0]    nxt_idx;
   logic [SEQ_W-1:0]         fwd_dist;
   logic                     in_order, ahead, in_window;
   logic [SLOT_IDX_W:0]      buf_sum, buf_wrap;
   logic [SLOT_IDX_W-1:0]    buf_idx;
   logic                     more;
   logic                     ram_wr_en;
   slot_entry_type           ram_wr_data;
   logic [SLOT_ENTRY_W-1:0]  ram_rd_data;
   slot_entry_type           slot_rd;

   awrr_ram #(
      .WIDTH (SLOT_ENTRY_W),
      .DEPTH (REORDER_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (buf_idx),
      .wr_data (ram_wr_data),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (exp_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign slot_rd = ram_rd_data;

   always_comb begin
      ram_wr_data.tag = pop_data.buffer_tag;
      ram_wr_data.len = pop_data.payload_len;
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // slot index of expected + 1, wrapping with the sequence space
   assign exp_idx_inc = (exp_ff == '1) ? '0 :
                        (exp_idx_ff == SLOT_IDX_W'(REORDER_DEPTH - 1)) ? '0 :
                        exp_idx_ff + 1'b1;

   assign fwd_dist  = pop_data.seq_num - exp_ff;
   assign in_order  = (pop_data.seq_num == exp_ff);
   assign ahead     = (pop_data.seq_num > exp_ff);
   assign in_window = (fwd_dist < SEQ_W'(REORDER_DEPTH));

   // slot of an early packet: expected slot plus distance, folded once
   assign buf_sum  = {1'b0, exp_idx_ff} + fwd_dist[SLOT_IDX_W:0];
   assign buf_wrap = (buf_sum >= (SLOT_IDX_W + 1)'(REORDER_DEPTH)) ?
                     buf_sum - (SLOT_IDX_W + 1)'(REORDER_DEPTH) : buf_sum;
   assign buf_idx  = buf_wrap[SLOT_IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      exp_in        = exp_ff;
      exp_idx_in    = exp_idx_ff;
      slot_valid_in = slot_valid_ff;
      run_cnt_in    = run_cnt_ff;
      out_valid_in  = out_valid_ff;
      dlv_valid_in  = dlv_valid_ff;
      dlv_seq_in    = dlv_seq_ff;
      dlv_tag_in    = dlv_tag_ff;
      dlv_len_in    = dlv_len_ff;
      ack_seq_in    = ack_seq_ff;
      ack_bits_in   = ack_bits_ff;
      status_in     = status_ff;
      last_in       = last_ff;
      pop_ready     = 1'b0;
      ram_wr_en     = 1'b0;
      nxt_idx       = exp_idx_ff;
      more          = 1'b0;

      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         // slot index of the new expected sequence is its low bits
         exp_in        = csr_wr_data;
         exp_idx_in    = csr_wr_data[SLOT_IDX_W-1:0];
         slot_valid_in = '0;
         state_in      = ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (pop_valid && out_free) begin
                  pop_ready    = 1'b1;
                  out_valid_in = 1'b1;
                  ack_seq_in   = pop_data.ack_seq;
                  ack_bits_in  = pop_data.ack_bits;
                  run_cnt_in   = RUN_CNT_W'(1);
                  dlv_valid_in = 1'b0;
                  dlv_seq_in   = '0;
                  dlv_tag_in   = '0;
                  dlv_len_in   = '0;
                  if (in_order) begin
                     dlv_valid_in              = 1'b1;
                     dlv_seq_in                = pop_data.seq_num;
                     dlv_tag_in                = pop_data.buffer_tag;
                     dlv_len_in                = pop_data.payload_len;
                     status_in                 = STATUS_IN_ORDER;
                     slot_valid_in[exp_idx_ff] = 1'b0;
                     exp_in                    = exp_ff + 1'b1;
                     exp_idx_in                = exp_idx_inc;
                     nxt_idx                   = exp_idx_inc;
                  end else if (ahead && in_window) begin
                     status_in              = STATUS_BUFFERED;
                     ram_wr_en              = 1'b1;
                     slot_valid_in[buf_idx] = 1'b1;
                  end else if (ahead) begin
                     status_in = STATUS_BEYOND;
                  end else begin
                     status_in = STATUS_DUPLICATE;
                  end
                  more     = slot_valid_ff[nxt_idx];
                  last_in  = !more;
                  state_in = more ? ST_READ : ST_IDLE;
               end
            end
            ST_READ: begin
               state_in = ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  out_valid_in              = 1'b1;
                  dlv_valid_in              = 1'b1;
                  dlv_seq_in                = exp_ff;
                  dlv_tag_in                = slot_rd.tag;
                  dlv_len_in                = slot_rd.len;
                  status_in                 = STATUS_IN_ORDER;
                  slot_valid_in[exp_idx_ff] = 1'b0;
                  exp_in                    = exp_ff + 1'b1;
                  exp_idx_in                = exp_idx_inc;
                  run_cnt_in                = run_cnt_ff + 1'b1;
                  more     = slot_valid_ff[exp_idx_inc]
                             && (run_cnt_ff != RUN_CNT_W'(MAX_RESULTS - 1));
                  last_in  = !more;
                  state_in = more ? ST_READ : ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         exp_ff        <= SEQ_W'(1);
         exp_idx_ff    <= SLOT_IDX_W'(1 % REORDER_DEPTH);
         slot_valid_ff <= '0;
         run_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         exp_ff        <= exp_in;
         exp_idx_ff    <= exp_idx_in;
         slot_valid_ff <= slot_valid_in;
         run_cnt_ff    <= run_cnt_in;
         out_valid_ff  <= out_valid_in;
         dlv_valid_ff  <= dlv_valid_in;
         dlv_seq_ff    <= dlv_seq_in;
         dlv_tag_ff    <= dlv_tag_in;
         dlv_len_ff    <= dlv_len_in;
         ack_seq_ff    <= ack_seq_in;
         ack_bits_ff   <= ack_bits_in;
         status_ff     <= status_in;
         last_ff       <= last_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.deliver_valid  = dlv_valid_ff;
   assign rsp_ch.deliver_seq    = dlv_seq_ff;
   assign rsp_ch.deliver_tag    = dlv_tag_ff;
   assign rsp_ch.deliver_len    = dlv_len_ff;
   assign rsp_ch.ack_seq        = ack_seq_ff;
   assign rsp_ch.ack_bits       = ack_bits_ff;
   assign rsp_ch.arrival_status = status_ff;
   assign rsp_ch.last_of_run    = last_ff;

endmodule
